/* hdl/aegc_pkg.sv */
`timescale 1ns / 1ps
package aegc_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	localparam logic [1:0] DEC_NONE = 2'd0;
	localparam logic [1:0] DEC_GZIP = 2'd1;
	localparam logic [1:0] DEC_WILD = 2'd2;

	// character flags decoded once at the front
	typedef struct packed {
		logic is_comma;
		logic is_semi;
		logic is_eq;
		logic is_ws;
		logic is_star;
		logic is_zero;
		logic is_nzdig;
		logic lc_q;
		logic lc_g;
		logic lc_z;
		logic lc_i;
		logic lc_p;
		logic lc_x;
		logic is_dash;
	} byte_class_t;

	typedef struct packed {
		logic        present;
		logic        last;
		byte_class_t cls;
	} byte_item_t;

	function automatic byte_class_t classify(input logic [7:0] c);
		logic [7:0]  lc;
		byte_class_t r;
		lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
		r.is_comma = (c == 8'h2C);
		r.is_semi  = (c == 8'h3B);
		r.is_eq    = (c == 8'h3D);
		r.is_ws    = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
		r.is_star  = (c == 8'h2A);
		r.is_zero  = (c == 8'h30);
		r.is_nzdig = (c >= 8'h31 && c <= 8'h39);
		r.lc_q     = (lc == 8'h71);
		r.lc_g     = (lc == 8'h67);
		r.lc_z     = (lc == 8'h7A);
		r.lc_i     = (lc == 8'h69);
		r.lc_p     = (lc == 8'h70);
		r.lc_x     = (lc == 8'h78);
		r.is_dash  = (c == 8'h2D);
		return r;
	endfunction

endpackage

/* hdl/accept_encoding_gzip_check_top.sv */
`timescale 1ns / 1ps
// channel | handshake           | payload
// --------+---------------------+-----------------------------------------
// input   | in_valid / in_stall | header_byte[7:0], byte_present, final_byte
// output  | out_valid/out_stall | accepts_gzip, decided_by[1:0]
//
// One header byte is taken per cycle while in_stall is low.
// out_valid rises once the final byte has passed the front classify register and one queue
// slot and then loaded the output register.
// Reset is asynchronous and clears all control state; there is no clearing pass.
// out_stall holds the result; the back keeps consuming bytes until the next final
// byte reaches the queue head, then the queue fills and only then in_stall rises.
module accept_encoding_gzip_check_top import aegc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] header_byte,
	input  logic       byte_present,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       accepts_gzip,
	output logic [1:0] decided_by
);

	logic       q_full;
	logic       q_push;
	byte_item_t q_item;
	logic       q_pop;
	logic       q_empty;
	byte_item_t q_head;

	aegc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.header_byte  (header_byte),
		.byte_present (byte_present),
		.final_byte   (final_byte),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (q_item)
	);

	aegc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	aegc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.accepts_gzip (accepts_gzip),
		.decided_by   (decided_by)
	);

endmodule

/* hdl/aegc_front.sv */
`timescale 1ns / 1ps
module aegc_front import aegc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] header_byte,
	input  logic       byte_present,
	input  logic       final_byte,
	input  logic       q_full,
	output logic       q_push,
	output byte_item_t q_item
);

	logic       valid_s1;
	byte_item_t item_s1;
	logic       advance;

	// stage moves on when empty or when its item enters the queue this cycle
	assign advance  = !valid_s1 || !q_full;
	assign in_stall = !advance;
	assign q_push   = valid_s1 && !q_full;
	assign q_item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			item_s1.present <= byte_present;
			item_s1.last    <= final_byte;
			item_s1.cls     <= classify(header_byte);
		end
	end

endmodule

/* hdl/aegc_queue.sv */
`timescale 1ns / 1ps
module aegc_queue import aegc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  byte_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output byte_item_t head
);

	byte_item_t           slot_q [QDEPTH];
	logic [QAW-1:0]       wr_ptr_q;
	logic [QAW-1:0]       rd_ptr_q;
	logic [QCW-1:0]       count_q;

	assign full  = (count_q == QCW'(QDEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* hdl/aegc_back.sv */
`timescale 1ns / 1ps
module aegc_back import aegc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  byte_item_t q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       accepts_gzip,
	output logic [1:0] decided_by
);

	typedef enum logic [3:0] {
		PH_TOKEN  = 4'b0001,
		PH_NAME   = 4'b0010,
		PH_QVALUE = 4'b0100,
		PH_SKIP   = 4'b1000
	} phase_t;

	localparam logic [1:0] TC_NONE = 2'd0;
	localparam logic [1:0] TC_GZIP = 2'd1;
	localparam logic [1:0] TC_WILD = 2'd2;

	localparam logic [1:0] NS_EMPTY = 2'd0;
	localparam logic [1:0] NS_Q     = 2'd1;
	localparam logic [1:0] NS_OTHER = 2'd2;

	localparam logic [1:0] VS_EMPTY = 2'd0;
	localparam logic [1:0] VS_ZERO  = 2'd1;
	localparam logic [1:0] VS_OTHER = 2'd2;

	typedef struct packed {
		phase_t     phase;
		logic [2:0] pos;
		logic [2:0] cand;
		logic       gap;
		logic [1:0] name_st;
		logic [1:0] val_st;
		logic       nz;
		logic       qs;
		logic       qr;
		logic       wseen;
		logic       wref;
		logic       dec;
		logic       acc;
	} pstate_t;

	function automatic pstate_t entry_reset(input pstate_t s);
		pstate_t r;
		r         = s;
		r.phase   = PH_TOKEN;
		r.pos     = 3'd0;
		r.cand    = 3'b111;
		r.gap     = 1'b0;
		r.name_st = NS_EMPTY;
		r.val_st  = VS_EMPTY;
		r.nz      = 1'b0;
		r.qs      = 1'b0;
		r.qr      = 1'b0;
		return r;
	endfunction

	function automatic pstate_t header_reset();
		pstate_t r;
		r       = '0;
		r       = entry_reset(r);
		r.wseen = 1'b0;
		r.wref  = 1'b0;
		r.dec   = 1'b0;
		r.acc   = 1'b0;
		return r;
	endfunction

	function automatic logic [1:0] token_class(input pstate_t s);
		logic [1:0] r;
		if (s.phase != PH_TOKEN) begin
			r = s.cand[1:0];
		end else if ((s.cand[0] && s.pos == 3'd4) || (s.cand[1] && s.pos == 3'd6)) begin
			r = TC_GZIP;
		end else if (s.cand[2] && s.pos == 3'd1) begin
			r = TC_WILD;
		end else begin
			r = TC_NONE;
		end
		return r;
	endfunction

	function automatic pstate_t settle_quality(input pstate_t s);
		pstate_t r;
		r    = s;
		r.qs = 1'b1;
		r.qr = (s.val_st == VS_ZERO) && !s.nz;
		return r;
	endfunction

	function automatic pstate_t end_entry(input pstate_t s);
		pstate_t    r;
		logic [1:0] cls;
		logic       refused;
		r = s;
		if (r.phase == PH_QVALUE) begin
			r = settle_quality(r);
		end
		cls     = token_class(r);
		refused = r.qs & r.qr;
		if (cls == TC_GZIP) begin
			r.dec = 1'b1;
			r.acc = !refused;
		end else if (cls == TC_WILD) begin
			r.wseen = 1'b1;
			r.wref  = refused;
		end
		return entry_reset(r);
	endfunction

	function automatic pstate_t take_byte(input pstate_t s, input byte_class_t c);
		pstate_t    r;
		logic [2:0] keep;
		r    = s;
		keep = 3'b000;
		if (c.is_comma) begin
			r = end_entry(s);
		end else begin
			unique case (s.phase)
				PH_TOKEN: begin
					if (c.is_semi) begin
						r.cand    = {1'b0, token_class(s)};
						r.phase   = PH_NAME;
						r.name_st = NS_EMPTY;
					end else if (c.is_ws) begin
						if (s.pos != 3'd0) begin
							r.gap = 1'b1;
						end
					end else begin
						if (!s.gap) begin
							case (s.pos)
								3'd0: keep = {c.is_star, c.lc_x, c.lc_g};
								3'd1: keep = {1'b0, c.is_dash, c.lc_z};
								3'd2: keep = {1'b0, c.lc_g, c.lc_i};
								3'd3: keep = {1'b0, c.lc_z, c.lc_p};
								3'd4: keep = {1'b0, c.lc_i, 1'b0};
								3'd5: keep = {1'b0, c.lc_p, 1'b0};
								default: keep = 3'b000;
							endcase
						end
						r.cand = s.cand & keep;
						if (s.pos != 3'd7) begin
							r.pos = s.pos + 3'd1;
						end
					end
				end
				PH_NAME: begin
					if (c.is_semi) begin
						r.name_st = NS_EMPTY;
					end else if (c.is_eq) begin
						r.phase  = (s.name_st == NS_Q && !s.qs) ? PH_QVALUE : PH_SKIP;
						r.val_st = VS_EMPTY;
						r.nz     = 1'b0;
					end else if (!c.is_ws) begin
						r.name_st = (s.name_st == NS_EMPTY && c.lc_q) ? NS_Q : NS_OTHER;
					end
				end
				PH_QVALUE: begin
					if (c.is_semi) begin
						r         = settle_quality(s);
						r.phase   = PH_NAME;
						r.name_st = NS_EMPTY;
					end else if (!c.is_ws) begin
						if (s.val_st == VS_EMPTY) begin
							r.val_st = c.is_zero ? VS_ZERO : VS_OTHER;
						end
						if (c.is_nzdig) begin
							r.nz = 1'b1;
						end
					end
				end
				PH_SKIP: begin
					if (c.is_semi) begin
						r.phase   = PH_NAME;
						r.name_st = NS_EMPTY;
					end
				end
				default: r = s;
			endcase
		end
		return r;
	endfunction

	pstate_t    st_q;
	pstate_t    st_n;
	pstate_t    st_w;
	logic       out_valid_q;
	logic       accepts_gzip_q;
	logic [1:0] decided_by_q;
	logic       load;
	logic       res_acc;
	logic [1:0] res_dec;

	// only a final item needs the output register; hold it while a result waits
	assign q_pop = !q_empty && !(q_head.last && out_valid_q && out_stall);
	assign load  = q_pop && q_head.last;

	always_comb begin
		st_w = st_q;
		if (q_head.present && !st_q.dec) begin
			st_w = take_byte(st_q, q_head.cls);
		end
		if (!st_w.dec) begin
			st_w = end_entry(st_w);
		end
		if (st_w.dec) begin
			res_acc = st_w.acc;
			res_dec = DEC_GZIP;
		end else if (st_w.wseen) begin
			res_acc = !st_w.wref;
			res_dec = DEC_WILD;
		end else begin
			res_acc = 1'b0;
			res_dec = DEC_NONE;
		end

		st_n = st_q;
		if (q_pop) begin
			if (q_head.last) begin
				st_n = header_reset();
			end else if (q_head.present && !st_q.dec) begin
				st_n = take_byte(st_q, q_head.cls);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= header_reset();
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_n;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			accepts_gzip_q <= res_acc;
			decided_by_q   <= res_dec;
		end
	end

	assign out_valid    = out_valid_q;
	assign accepts_gzip = accepts_gzip_q;
	assign decided_by   = decided_by_q;

endmodule
